>>> sv/byte_record_ring_fifo_top_macros.svh
// assertion helpers used by brf_ctrl
`ifndef BYTE_RECORD_RING_FIFO_TOP_MACROS_SVH
`define BYTE_RECORD_RING_FIFO_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define BRF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brf assertion failed");

// next-cycle implication, checked out of reset
`define BRF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brf assertion failed");

`endif

>>> sv/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Types and codes shared by the byte/record ring fifo files.
// ----------------------------------------------------------------------------
package brf_pkg;

	// command codes carried in the mode field
	localparam logic [3:0] MODE_PUT_BEGIN  = 4'd0;
	localparam logic [3:0] MODE_REC_PUT    = 4'd1;
	localparam logic [3:0] MODE_PUT_BYTE   = 4'd2;
	localparam logic [3:0] MODE_GET        = 4'd3;
	localparam logic [3:0] MODE_REC_GET    = 4'd4;
	localparam logic [3:0] MODE_PEEK       = 4'd5;
	localparam logic [3:0] MODE_REC_PEEK   = 4'd6;
	localparam logic [3:0] MODE_POP        = 4'd7;
	localparam logic [3:0] MODE_FLUSH      = 4'd8;

	// status codes
	localparam logic [2:0] STS_OK          = 3'd0;
	localparam logic [2:0] STS_FULL        = 3'd1;
	localparam logic [2:0] STS_NOT_ENOUGH  = 3'd2;
	localparam logic [2:0] STS_INVALID     = 3'd3;
	localparam logic [2:0] STS_EMPTY       = 3'd4;
	localparam logic [2:0] STS_TOO_SMALL   = 3'd5;
	localparam logic [2:0] STS_NO_PUT      = 3'd6;

	// configuration register indexes
	localparam logic CFG_ALLOW_WRAP = 1'b0;
	localparam logic CFG_SIZE       = 1'b1;

	// record header length in bytes
	localparam int HDR_SIZE = 2;

	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] data_byte;
		logic [6:0] length;
		logic [7:0] offset;
	} brf_in_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       has_byte;
		logic       last;
		logic [2:0] status;
		logic [7:0] record_size;
		logic [7:0] used_count;
		logic [7:0] free_count;
	} brf_out_t;

	typedef struct packed {
		logic       we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic       re;
		logic [7:0] raddr;
	} brf_mem_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVCHK,
		ST_POPCHK,
		ST_SKCHK,
		ST_H0,
		ST_H1,
		ST_H2,
		ST_PUTH0,
		ST_PUTH1,
		ST_RD,
		ST_CAP,
		ST_FIN
	} brf_state_t;

endpackage

>>> sv/byte_record_ring_fifo_top.sv
// ----------------------------------------------------------------------------
// byte_record_ring_fifo_top
// Byte/record ring fifo: sequencer, ring memory and output register.
// ----------------------------------------------------------------------------
// Single-result commands end in ST_FIN, which loads the output register; record
// puts first write the header in ST_PUTH0 and ST_PUTH1. Byte reads alternate
// ST_RD and ST_CAP per byte on the one read port; each record header walked
// (skip, pop, eviction) passes a check state, ST_H0, ST_H1 and ST_H2. A new
// command is taken once the previous one has issued its last beat. Reset clears
// pointers, mode latches and the open put; the ring memory is not cleared.
module byte_record_ring_fifo_top
	import brf_pkg::*;
#(
	parameter int DEPTH     = 256,
	parameter int MAX_BURST = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  brf_in_t    in_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	output logic       out_valid,
	input  logic       out_stall,
	output brf_out_t   out_data
);

	localparam int MEM_DEPTH = (DEPTH < 256) ? DEPTH : 256;

	brf_mem_req_t mem_req;
	logic [7:0]   mem_rdata;
	logic         ld, out_free, out_valid_q;
	brf_out_t     res, out_data_q;

	assign out_free = !out_valid_q || !out_stall;

	brf_ctrl #(
		.MEM_DEPTH(MEM_DEPTH),
		.MAX_BURST(MAX_BURST)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_free (out_free),
		.ld       (ld),
		.res      (res),
		.mem_req  (mem_req),
		.mem_rdata(mem_rdata)
	);

	brf_ring_mem #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rdata(mem_rdata)
	);

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> sv/brf_ring_mem.sv
// ----------------------------------------------------------------------------
// brf_ring_mem
// Byte ring storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module brf_ring_mem
	import brf_pkg::*;
#(
	parameter int MEM_DEPTH = 256
) (
	input  logic         clk,
	input  brf_mem_req_t req,
	output logic [7:0]   rdata
);

	localparam int AW = $clog2(MEM_DEPTH);

	logic [7:0] mem [MEM_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr[AW-1:0]];
		end
	end

endmodule

>>> sv/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl
// Command sequencer: pointers, mode latches, header walks and byte streams.
// ----------------------------------------------------------------------------
module brf_ctrl
	import brf_pkg::*;
#(
	parameter int MEM_DEPTH = 256,
	parameter int MAX_BURST = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  brf_in_t      in_data,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [8:0]   cfg_data,
	input  logic         out_free,
	output logic         ld,
	output brf_out_t     res,
	output brf_mem_req_t mem_req,
	input  logic [7:0]   mem_rdata
);

	`include "byte_record_ring_fifo_top_macros.svh"

	brf_state_t state_q, state_d;
	logic [7:0]  wr_q, wr_d, rd_q, rd_d;
	logic        bmode_q, bmode_d, rmode_q, rmode_d;
	logic [6:0]  left_q, left_d;
	logic        wrap_q, wrap_d;
	logic [8:0]  size_q, size_d;
	logic [3:0]  op_q, op_d;
	logic [6:0]  n_q, n_d, need_q, need_d, cnt_q, cnt_d;
	logic [7:0]  idx_q, idx_d, i_q, i_d, ptr_q, ptr_d, lo_q, lo_d, rsize_q, rsize_d;
	logic [16:0] pos_q, pos_d;
	logic [2:0]  status_q, status_d;

	logic [7:0]  fill, cap, freeb, start;
	logic [6:0]  n_sat, need_in;
	logic        rec;
	logic [15:0] hdr_s;
	logic [16:0] hs2, fill17, pos_end;

	function automatic logic [7:0] wrap_add(logic [7:0] b, logic [7:0] o, logic [8:0] sz);
		logic [9:0] s;
		s = {2'b00, b} + {2'b00, o};
		if (s >= {1'b0, sz}) s = s - {1'b0, sz};
		return s[7:0];
	endfunction

	// fill level and free room from the pointers
	always_comb begin
		if (wr_q >= rd_q) fill = wr_q - rd_q;
		else fill = 8'(size_q - {1'b0, rd_q} + {1'b0, wr_q});
		cap     = 8'(size_q - 9'd1);
		freeb   = cap - fill;
		fill17  = {9'd0, fill};
		hdr_s   = {mem_rdata, lo_q};
		hs2     = {1'b0, hdr_s} + 17'd2;
		pos_end = pos_q + hs2;
		n_sat   = (in_data.length > 7'(MAX_BURST)) ? 7'(MAX_BURST) : in_data.length;
		rec     = (in_data.mode == MODE_REC_PUT);
		need_in = rec ? 7'(n_sat + 7'(HDR_SIZE)) : n_sat;
		start   = (in_data.mode == MODE_PEEK) ? in_data.offset : 8'd0;
	end

	// next state and outputs
	always_comb begin
		state_d = state_q; wr_d = wr_q; rd_d = rd_q; bmode_d = bmode_q; rmode_d = rmode_q;
		left_d = left_q; wrap_d = wrap_q; size_d = size_q; op_d = op_q; n_d = n_q;
		need_d = need_q; cnt_d = cnt_q; idx_d = idx_q; i_d = i_q; ptr_d = ptr_q;
		lo_d = lo_q; rsize_d = rsize_q; pos_d = pos_q; status_d = status_q;
		in_stall = (state_q != ST_IDLE);
		ld = 1'b0;
		res = '0;
		res.used_count = fill;
		res.free_count = freeb;
		res.status = status_q;
		res.record_size = rsize_q;
		mem_req = '0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_d = in_data.mode; n_d = n_sat; need_d = need_in;
					status_d = STS_OK; rsize_d = 8'd0; pos_d = '0; i_d = 8'd0;
					state_d = ST_FIN;
					if (left_q != 7'd0 && in_data.mode != MODE_PUT_BYTE
							&& in_data.mode != MODE_FLUSH) begin
						status_d = STS_INVALID;
					end else begin
						case (in_data.mode)
							MODE_PUT_BEGIN, MODE_REC_PUT: begin
								if (rec ? bmode_q : rmode_q) begin
									status_d = STS_INVALID;
								end else begin
									if (rec) rmode_d = 1'b1;
									else bmode_d = 1'b1;
									if (freeb < {1'b0, need_in}) begin
										if (!wrap_q || cap < {1'b0, need_in}) begin
											status_d = STS_FULL;
										end else if (rec) begin
											state_d = ST_EVCHK;
										end else begin
											rd_d = wrap_add(rd_q, 8'({1'b0, need_in} - freeb),
												size_q);
											left_d = n_sat;
										end
									end else if (rec) begin
										state_d = ST_PUTH0;
									end else begin
										left_d = n_sat;
									end
								end
							end
							MODE_PUT_BYTE: begin
								if (left_q == 7'd0) begin
									status_d = STS_NO_PUT;
								end else begin
									mem_req.we = 1'b1;
									mem_req.waddr = wr_q;
									mem_req.wdata = in_data.data_byte;
									wr_d = wrap_add(wr_q, 8'd1, size_q);
									left_d = left_q - 7'd1;
								end
							end
							MODE_GET, MODE_PEEK: begin
								if (in_data.mode == MODE_GET && rmode_q) begin
									status_d = STS_INVALID;
								end else if ({1'b0, fill} < {2'b00, n_sat} + {1'b0, start}) begin
									status_d = STS_NOT_ENOUGH;
								end else if (n_sat != 7'd0) begin
									ptr_d = wrap_add(rd_q, start, size_q);
									if (in_data.mode == MODE_GET) begin
										rd_d = wrap_add(rd_q, {1'b0, n_sat}, size_q);
									end
									cnt_d = n_sat;
									state_d = ST_RD;
								end
							end
							MODE_REC_GET, MODE_REC_PEEK: begin
								if (!rmode_q) status_d = STS_INVALID;
								else if (fill == 8'd0) status_d = STS_EMPTY;
								else begin
									idx_d = (in_data.mode == MODE_REC_PEEK) ? in_data.offset : 8'd0;
									state_d = ST_SKCHK;
								end
							end
							MODE_POP: begin
								if (rmode_q) begin
									cnt_d = n_sat;
									state_d = ST_POPCHK;
								end else if (fill < {1'b0, n_sat}) begin
									rd_d = wr_q;
								end else begin
									rd_d = wrap_add(rd_q, {1'b0, n_sat}, size_q);
								end
							end
							MODE_FLUSH: begin
								rd_d = wr_q;
								left_d = 7'd0;
							end
							default: status_d = STS_INVALID;
						endcase
					end
				end
			end
			// eviction loop for a wrapping record put
			ST_EVCHK: begin
				pos_d = '0;
				if (freeb >= {1'b0, need_q}) state_d = ST_PUTH0;
				else if (fill < 8'(HDR_SIZE)) rd_d = wr_q;
				else state_d = ST_H0;
			end
			// record pop loop
			ST_POPCHK: begin
				pos_d = '0;
				if (cnt_q == 7'd0) state_d = ST_FIN;
				else if (fill < 8'(HDR_SIZE)) begin
					rd_d = wr_q;
					state_d = ST_FIN;
				end else state_d = ST_H0;
			end
			// record index walk
			ST_SKCHK: begin
				if (fill17 < pos_q + 17'(HDR_SIZE)) begin
					status_d = STS_NOT_ENOUGH;
					state_d = ST_FIN;
				end else state_d = ST_H0;
			end
			// header low byte read
			ST_H0: begin
				mem_req.re = 1'b1;
				mem_req.raddr = wrap_add(rd_q, pos_q[7:0], size_q);
				state_d = ST_H1;
			end
			ST_H1: begin
				lo_d = mem_rdata;
				mem_req.re = 1'b1;
				mem_req.raddr = wrap_add(rd_q, pos_q[7:0] + 8'd1, size_q);
				state_d = ST_H2;
			end
			// header complete: act on it
			ST_H2: begin
				case (op_q)
					MODE_REC_PUT, MODE_POP: begin
						if (fill17 < hs2) rd_d = wr_q;
						else rd_d = wrap_add(rd_q, hs2[7:0], size_q);
						if (op_q == MODE_REC_PUT) state_d = ST_EVCHK;
						else if (fill17 < hs2) state_d = ST_FIN;
						else begin
							cnt_d = cnt_q - 7'd1;
							state_d = ST_POPCHK;
						end
					end
					default: begin
						if (i_q != idx_q) begin
							pos_d = pos_end;
							i_d = i_q + 8'd1;
							state_d = ST_SKCHK;
						end else begin
							state_d = ST_FIN;
							rsize_d = hdr_s[7:0];
							if (hdr_s > {9'd0, n_q}) begin
								status_d = STS_TOO_SMALL;
							end else if (fill17 < pos_end) begin
								status_d = STS_NOT_ENOUGH;
								rsize_d = 8'd0;
							end else begin
								ptr_d = wrap_add(rd_q, pos_q[7:0] + 8'(HDR_SIZE), size_q);
								if (op_q == MODE_REC_GET) begin
									rd_d = wrap_add(rd_q, pos_end[7:0], size_q);
								end
								cnt_d = hdr_s[6:0];
								if (hdr_s != 16'd0) state_d = ST_RD;
							end
						end
					end
				endcase
			end
			// record header write
			ST_PUTH0: begin
				mem_req.we = 1'b1;
				mem_req.waddr = wr_q;
				mem_req.wdata = {1'b0, n_q};
				wr_d = wrap_add(wr_q, 8'd1, size_q);
				state_d = ST_PUTH1;
			end
			ST_PUTH1: begin
				mem_req.we = 1'b1;
				mem_req.waddr = wr_q;
				mem_req.wdata = 8'd0;
				wr_d = wrap_add(wr_q, 8'd1, size_q);
				left_d = n_q;
				state_d = ST_FIN;
			end
			// byte stream: read, then deliver
			ST_RD: begin
				if (out_free) begin
					mem_req.re = 1'b1;
					mem_req.raddr = ptr_q;
					ptr_d = wrap_add(ptr_q, 8'd1, size_q);
					cnt_d = cnt_q - 7'd1;
					state_d = ST_CAP;
				end
			end
			ST_CAP: begin
				ld = 1'b1;
				res.read_byte = mem_rdata;
				res.has_byte = 1'b1;
				res.last = (cnt_q == 7'd0);
				state_d = (cnt_q == 7'd0) ? ST_IDLE : ST_RD;
			end
			ST_FIN: begin
				if (out_free) begin
					ld = 1'b1;
					res.last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// configuration writes: the user must make them only while idle; the block itself does not enforce this
		if (cfg_we) begin
			case (cfg_index)
				CFG_ALLOW_WRAP: wrap_d = cfg_data[0];
				CFG_SIZE: begin
					if (cfg_data < 9'd2) size_d = 9'd2;
					else if (cfg_data > 9'(MEM_DEPTH)) size_d = 9'(MEM_DEPTH);
					else size_d = cfg_data;
					wr_d = 8'd0;
					rd_d = 8'd0;
					left_d = 7'd0;
				end
				default: wrap_d = wrap_q;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wr_q <= 8'd0;
			rd_q <= 8'd0;
			bmode_q <= 1'b0;
			rmode_q <= 1'b0;
			left_q <= 7'd0;
			wrap_q <= 1'b0;
			size_q <= 9'(MEM_DEPTH);
		end else begin
			state_q <= state_d;
			wr_q <= wr_d;
			rd_q <= rd_d;
			bmode_q <= bmode_d;
			rmode_q <= rmode_d;
			left_q <= left_d;
			wrap_q <= wrap_d;
			size_q <= size_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		op_q <= op_d;
		n_q <= n_d;
		need_q <= need_d;
		cnt_q <= cnt_d;
		idx_q <= idx_d;
		i_q <= i_d;
		ptr_q <= ptr_d;
		lo_q <= lo_d;
		rsize_q <= rsize_d;
		pos_q <= pos_d;
		status_q <= status_d;
	end

	`BRF_ASSERT_NOW(a_ld_free, ld, out_free)
	`BRF_ASSERT_NOW(a_fill_cap, 1'b1, fill <= cap)
	`BRF_ASSERT_NOW(a_cap_after_rd, state_q == ST_CAP, $past(state_q) == ST_RD)

endmodule
